// File: src/http_host_header_extractor_macros.svh
// assertion macros for the http host header extractor
// no dependencies; included by the top level only
`ifndef HTTP_HOST_HEADER_EXTRACTOR_MACROS_SVH
`define HTTP_HOST_HEADER_EXTRACTOR_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define HHE_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define HHE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/hhe_pkg.sv
// constants for the http host header extractor
// no dependencies; used by http_host_header_extractor
package hhe_pkg;

    localparam int unsigned POS_W  = 3;
    localparam int unsigned LEN_W  = 6;

    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_LF = 8'h0a;

    // line index where the host name begins, prefix length, position cap
    localparam logic [POS_W-1:0] HOST_DATA_INDEX = 3'd6;
    localparam logic [POS_W-1:0] PREFIX_LEN      = 3'd5;
    localparam logic [POS_W-1:0] POS_MAX         = 3'd7;

    localparam logic [LEN_W-1:0] LEN_MAX = 6'd63;

    // expected character of "Host:" at a line position
    function automatic logic [7:0] prefix_char(input logic [POS_W-1:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = 8'h48; // H
            3'd1:    ch = 8'h6f; // o
            3'd2:    ch = 8'h73; // s
            3'd3:    ch = 8'h74; // t
            3'd4:    ch = 8'h3a; // :
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: src/http_host_header_extractor.sv
// Accepts one payload byte per cycle and returns each item's result (if any) in the next cycle
// from an output register; a new item is taken every cycle unless that register holds a result
// the consumer has not taken. All per-byte work is a single pass of compare and count logic
// between the state registers and the output register. Host bytes come out one item late (the
// byte is held so the closing CR never goes out), at most HOST_BUFFER_BYTES-1 per packet, and
// every packet ends in exactly one verdict item with the found flag and the length capped at 63.
//
// top level of the http host header extractor
// depends on hhe_pkg and http_host_header_extractor_macros.svh
`include "http_host_header_extractor_macros.svh"

module http_host_header_extractor #(
    parameter int unsigned HOST_BUFFER_BYTES = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_payload_byte,
    input  logic       s_packet_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_is_verdict,
    output logic       m_host_found,
    output logic [5:0] m_host_length
);

    localparam int unsigned CNT_W = $clog2(HOST_BUFFER_BYTES);
    localparam int unsigned EXT_W = (CNT_W > hhe_pkg::LEN_W) ? CNT_W : hhe_pkg::LEN_W;
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(HOST_BUFFER_BYTES - 1);

    // line and packet state
    logic [hhe_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                      prefix_reg, prefix_next;
    logic                      prev_cr_reg, prev_cr_next;
    logic [7:0]                held_byte_reg, held_byte_next;
    logic                      held_valid_reg, held_valid_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      first_line_reg, first_line_next;
    logic                      sent_reg, sent_next;

    // output register
    logic       m_valid_reg, m_valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       verdict_reg, verdict_next;
    logic       found_reg, found_next;
    logic [5:0] length_reg, length_next;

    logic                   accept;
    logic                   res_valid;
    logic [EXT_W-1:0]       count_ext;
    logic [hhe_pkg::LEN_W-1:0] count_sat;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // emitted count as reported, capped at 63
    assign count_ext = EXT_W'(count_reg);
    assign count_sat = (count_ext > EXT_W'(hhe_pkg::LEN_MAX)) ? hhe_pkg::LEN_MAX
                                                              : count_ext[hhe_pkg::LEN_W-1:0];

    // per-item state update and result
    always_comb begin
        pos_next        = pos_reg;
        prefix_next     = prefix_reg;
        prev_cr_next    = prev_cr_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        count_next      = count_reg;
        first_line_next = first_line_reg;
        sent_next       = sent_reg;
        res_valid       = 1'b0;
        byte_next       = 8'h00;
        verdict_next    = 1'b0;
        found_next      = 1'b0;
        length_next     = '0;

        if (accept) begin
            if (sent_reg) begin
                // rest of packet ignored after the verdict
            end else if (prev_cr_reg && s_payload_byte == hhe_pkg::CH_LF) begin
                // end of line
                if (prefix_reg && pos_reg >= hhe_pkg::HOST_DATA_INDEX) begin
                    res_valid    = 1'b1;
                    verdict_next = 1'b1;
                    found_next   = 1'b1;
                    length_next  = count_sat;
                    sent_next    = 1'b1;
                end else if (pos_reg == 3'd1 && !first_line_reg) begin
                    res_valid    = 1'b1;
                    verdict_next = 1'b1;
                    sent_next    = 1'b1;
                end else begin
                    pos_next        = '0;
                    prefix_next     = 1'b1;
                    prev_cr_next    = 1'b0;
                    held_valid_next = 1'b0;
                    held_byte_next  = 8'h00;
                    first_line_next = 1'b0;
                    if (s_packet_end) begin
                        res_valid    = 1'b1;
                        verdict_next = 1'b1;
                    end
                end
            end else begin
                // emit the held host byte while under the limit
                if (held_valid_reg && count_reg < LIMIT && !s_packet_end) begin
                    res_valid  = 1'b1;
                    byte_next  = held_byte_reg;
                    count_next = count_reg + CNT_W'(1);
                end
                held_valid_next = prefix_reg && pos_reg >= hhe_pkg::HOST_DATA_INDEX;
                if (prefix_reg && pos_reg >= hhe_pkg::HOST_DATA_INDEX) begin
                    held_byte_next = s_payload_byte;
                end
                if (pos_reg < hhe_pkg::PREFIX_LEN &&
                    s_payload_byte != hhe_pkg::prefix_char(pos_reg)) begin
                    prefix_next = 1'b0;
                end
                prev_cr_next = (s_payload_byte == hhe_pkg::CH_CR);
                pos_next     = (pos_reg < hhe_pkg::POS_MAX) ? pos_reg + 3'd1 : hhe_pkg::POS_MAX;
                if (s_packet_end) begin
                    res_valid    = 1'b1;
                    byte_next    = 8'h00;
                    verdict_next = 1'b1;
                    found_next   = 1'b0;
                    length_next  = '0;
                end
            end

            // packet end returns everything to the packet start state
            if (s_packet_end) begin
                pos_next        = '0;
                prefix_next     = 1'b1;
                prev_cr_next    = 1'b0;
                held_byte_next  = 8'h00;
                held_valid_next = 1'b0;
                count_next      = '0;
                first_line_next = 1'b1;
                sent_next       = 1'b0;
            end
        end
    end

    // output register occupancy
    always_comb begin
        if (accept) begin
            m_valid_next = res_valid;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            prefix_reg     <= 1'b1;
            prev_cr_reg    <= 1'b0;
            held_valid_reg <= 1'b0;
            count_reg      <= '0;
            first_line_reg <= 1'b1;
            sent_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            prefix_reg     <= prefix_next;
            prev_cr_reg    <= prev_cr_next;
            held_valid_reg <= held_valid_next;
            count_reg      <= count_next;
            first_line_reg <= first_line_next;
            sent_reg       <= sent_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        held_byte_reg <= held_byte_next;
        if (accept) begin
            byte_reg    <= byte_next;
            verdict_reg <= verdict_next;
            found_reg   <= found_next;
            length_reg  <= length_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_is_verdict  = verdict_reg;
    assign m_host_found  = found_reg;
    assign m_host_length = length_reg;

    // checks
    `HHE_ASSERT_NEXT(a_end_gives_verdict, aclk, aresetn,
        accept && s_packet_end && !sent_reg, m_valid && m_is_verdict,
        "packet end without verdict")
    `HHE_ASSERT_NEXT(a_end_clears_state, aclk, aresetn,
        accept && s_packet_end,
        first_line_reg && !sent_reg && count_reg == '0 && !held_valid_reg,
        "state not cleared at packet end")
    `HHE_ASSERT_SAME(a_held_only_in_host, aclk, aresetn,
        held_valid_reg, prefix_reg && pos_reg == hhe_pkg::POS_MAX,
        "held byte outside host data")
    `HHE_ASSERT_SAME(a_byte_item_clean, aclk, aresetn,
        m_valid && !m_is_verdict, !m_host_found && m_host_length == '0,
        "host byte item carries verdict fields")

endmodule

// File: tb/sv/http_host_header_extractor_tb.sv
// self-checking testbench for the http host header extractor
// holds its own line parser that predicts host bytes and verdicts per packet
// depends on hhe_pkg and the http_host_header_extractor top level
`timescale 1ns / 100ps

module http_host_header_extractor_tb;

    localparam int unsigned HOST_BUF_BYTES = 64;
    localparam int unsigned RX_HOLD_CYCLES = 400;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam logic [39:0] HOST_TAG       = "Host:";

    typedef struct packed {
        logic [7:0] data;
        logic       verdict;
        logic       found;
        logic [5:0] length;
    } host_item_t;

    logic       aclk;
    logic       aresetn        = 1'b0;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [7:0] s_payload_byte = '0;
    logic       s_packet_end   = 1'b0;
    logic       m_valid;
    logic       m_ready        = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_is_verdict;
    logic       m_host_found;
    logic [5:0] m_host_length;

    // predictor state, one packet at a time
    logic [2:0]  line_pos;
    logic        prefix_ok;
    logic        prev_cr;
    logic [7:0]  held;
    logic        held_ok;
    int unsigned sent_host_bytes;
    logic        first_line;
    logic        verdict_done;

    host_item_t  host_results_due[$];
    logic [7:0]  pkt_bytes[$];
    int unsigned bytes_accepted = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned rx_hold_left   = 0;
    bit          rx_hold_req    = 1'b0;
    bit          idling_on      = 1'b1;

    http_host_header_extractor #(
        .HOST_BUFFER_BYTES(HOST_BUF_BYTES)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_payload_byte(s_payload_byte),
        .s_packet_end  (s_packet_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_is_verdict  (m_is_verdict),
        .m_host_found  (m_host_found),
        .m_host_length (m_host_length)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void clear_packet_state();
        line_pos        = '0;
        prefix_ok       = 1'b1;
        prev_cr         = 1'b0;
        held            = '0;
        held_ok         = 1'b0;
        sent_host_bytes = 0;
        first_line      = 1'b1;
        verdict_done    = 1'b0;
    endfunction

    function automatic void expect_verdict(input logic found);
        host_item_t v;
        v.data    = '0;
        v.verdict = 1'b1;
        v.found   = found;
        v.length  = '0;
        if (found)
            v.length = (sent_host_bytes > hhe_pkg::LEN_MAX) ? hhe_pkg::LEN_MAX
                                                            : sent_host_bytes[5:0];
        host_results_due.push_back(v);
        verdict_done = 1'b1;
    endfunction

    function automatic void predict_host_results(input logic [7:0] b, input logic last);
        logic [2:0] pos;
        host_item_t h;
        pos = line_pos;
        // rest of packet is ignored once the verdict is out
        if (verdict_done) begin
            if (last)
                clear_packet_state();
            return;
        end
        // crlf closes a line
        if (prev_cr && b == hhe_pkg::CH_LF) begin
            if (prefix_ok && pos >= hhe_pkg::HOST_DATA_INDEX)
                expect_verdict(1'b1);
            else if (pos == 3'd1 && !first_line)
                expect_verdict(1'b0);
            else begin
                line_pos   = '0;
                prefix_ok  = 1'b1;
                prev_cr    = 1'b0;
                held_ok    = 1'b0;
                held       = '0;
                first_line = 1'b0;
                if (last)
                    expect_verdict(1'b0);
            end
            if (last)
                clear_packet_state();
            return;
        end
        // release the held host byte while under the buffer cap
        if (held_ok && sent_host_bytes < HOST_BUF_BYTES - 1 && !last) begin
            h.data    = held;
            h.verdict = 1'b0;
            h.found   = 1'b0;
            h.length  = '0;
            host_results_due.push_back(h);
            sent_host_bytes++;
        end
        held_ok = 1'b0;
        if (prefix_ok && pos >= hhe_pkg::HOST_DATA_INDEX) begin
            held    = b;
            held_ok = 1'b1;
        end
        if (pos < hhe_pkg::PREFIX_LEN && b != HOST_TAG[8*(4-pos) +: 8])
            prefix_ok = 1'b0;
        prev_cr  = (b == hhe_pkg::CH_CR);
        line_pos = (pos < hhe_pkg::POS_MAX) ? pos + 3'd1 : hhe_pkg::POS_MAX;
        if (last) begin
            expect_verdict(1'b0);
            clear_packet_state();
        end
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%t mismatch: %s", $realtime, msg);
    endfunction

    function automatic void check_host_result(input host_item_t got);
        host_item_t want;
        if (host_results_due.size() == 0) begin
            log_mismatch($sformatf("unexpected item byte=%02h verdict=%0b found=%0b len=%0d",
                got.data, got.verdict, got.found, got.length));
            return;
        end
        want = host_results_due.pop_front();
        if (got.data !== want.data || got.verdict !== want.verdict ||
            got.found !== want.found || got.length !== want.length)
            log_mismatch($sformatf(
                "item %0d expected byte=%02h verdict=%0b found=%0b len=%0d, got byte=%02h verdict=%0b found=%0b len=%0d",
                results_seen, want.data, want.verdict, want.found, want.length,
                got.data, got.verdict, got.found, got.length));
        results_seen++;
    endfunction

    // results are checked before the same edge's input is predicted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                check_host_result({m_out_byte, m_is_verdict, m_host_found, m_host_length});
            if (s_valid && s_ready)
                predict_host_results(s_payload_byte, s_packet_end);
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (rx_hold_req) begin
            rx_hold_left = RX_HOLD_CYCLES;
            rx_hold_req  = 1'b0;
        end
        if (rx_hold_left > 0) begin
            m_ready <= 1'b0;
            rx_hold_left--;
        end else
            m_ready <= !(idling_on && $urandom_range(99) < 16);
    end

    // watchdog on cycles where no item moves on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------------------------------------------------------- sender

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (idling_on && $urandom_range(99) < 16) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_payload_byte <= b;
        s_packet_end   <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        bytes_accepted++;
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt_bytes.size(); i++)
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
        pkt_bytes.delete();
    endtask

    task automatic wait_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (host_results_due.size() != 0)
            @(posedge aclk);
    endtask

    // ---------------------------------------------------------------- packet builders

    task automatic put_byte(input logic [7:0] b);
        pkt_bytes.push_back(b);
    endtask

    task automatic put_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            pkt_bytes.push_back(txt[i]);
    endtask

    task automatic put_crlf();
        pkt_bytes.push_back(hhe_pkg::CH_CR);
        pkt_bytes.push_back(hhe_pkg::CH_LF);
    endtask

    task automatic put_word(input int unsigned n);
        repeat (n)
            pkt_bytes.push_back(8'($urandom_range(33, 126)));
    endtask

    // host line with a name of the given length, lone cr sprinkled in
    task automatic put_host_line(input int unsigned name_len);
        put_text("Host:");
        if ($urandom_range(3) != 0)
            put_byte(" ");
        repeat (name_len) begin
            if ($urandom_range(15) == 0)
                put_byte(hhe_pkg::CH_CR);
            else
                put_byte(8'($urandom_range(33, 126)));
        end
        put_crlf();
    endtask

    task automatic build_random_packet();
        int unsigned n;
        int unsigned cut;
        // pure noise, biased toward line terminators
        if ($urandom_range(99) < 12) begin
            n = $urandom_range(1, 12);
            repeat (n) begin
                case ($urandom_range(3))
                    0:       put_byte(hhe_pkg::CH_CR);
                    1:       put_byte(hhe_pkg::CH_LF);
                    default: put_byte(8'($urandom_range(255)));
                endcase
            end
            return;
        end
        // empty first line does not end the search
        if ($urandom_range(9) == 0)
            put_crlf();
        if ($urandom_range(4) != 0) begin
            put_text("GET /");
            put_word($urandom_range(3));
            put_crlf();
        end
        // header lines that nearly match the host tag
        if ($urandom_range(2) == 0) begin
            case ($urandom_range(4))
                0:       put_text("host:");
                1:       put_text("HOST:");
                2:       put_text("Hos:");
                3:       put_text("Hostx");
                default: put_text("X-Host:");
            endcase
            put_word($urandom_range(4));
            put_crlf();
        end
        // empty line before the host line ends the search
        if ($urandom_range(7) == 0)
            put_crlf();
        if ($urandom_range(9) != 0)
            put_host_line(($urandom_range(19) == 0) ? $urandom_range(58, 72)
                                                    : $urandom_range(10));
        if ($urandom_range(1) != 0) begin
            put_text("A: ");
            put_word($urandom_range(3));
            put_crlf();
        end
        put_crlf();
        n = $urandom_range(4);
        repeat (n)
            put_byte(8'($urandom_range(255)));
        // packet cut off anywhere
        if ($urandom_range(7) == 0) begin
            cut = $urandom_range(1, pkt_bytes.size());
            while (pkt_bytes.size() > cut)
                void'(pkt_bytes.pop_back());
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed_cases();
        // short host line ending on the packet's last byte
        put_text("Host:");
        put_crlf();
        send_packet();
        // empty first line skipped, second empty line ends search, trailing byte ignored
        put_crlf();
        put_crlf();
        put_byte(8'h7f);
        send_packet();
        // lone cr as host byte, held byte dropped at packet end
        put_text("Host: ");
        put_byte(hhe_pkg::CH_CR);
        put_byte(8'h00);
        put_byte(8'hff);
        send_packet();
        // single-byte packet
        put_byte(8'h80);
        send_packet();
    endtask

    task automatic test_output_backpressure();
        // long host name while the receiver holds off, so the input stalls
        rx_hold_req = 1'b1;
        put_text("Host: ");
        repeat (70)
            put_byte(8'($urandom_range(97, 122)));
        put_crlf();
        put_byte(8'h55);
        send_packet();
        // sender waits for every result before going on
        wait_until_drained();
    endtask

    task automatic test_back_to_back();
        int unsigned start;
        start     = bytes_accepted;
        idling_on = 1'b0;
        while (bytes_accepted - start < 100) begin
            build_random_packet();
            send_packet();
        end
        idling_on = 1'b1;
    endtask

    task automatic test_random_requests();
        bit paused;
        paused = 1'b0;
        while (bytes_accepted < 600) begin
            build_random_packet();
            send_packet();
            if (!paused && bytes_accepted > 400) begin
                wait_until_drained();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        clear_packet_state();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_output_backpressure();
        test_back_to_back();
        test_random_requests();
        wait_until_drained();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && host_results_due.size() == 0)
            $display("Regression PASS");
        else begin
            if (host_results_due.size() != 0)
                $display("%0d expected items never arrived", host_results_due.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
